/* rtl/core/rsp_pkg.sv */
// Shared constants, codes and types for the run-length sprite pixel fetch.
package rsp_pkg;

	localparam int unsigned CODE_DEPTH = 65536;
	localparam int unsigned CODE_AW    = $clog2(CODE_DEPTH);
	localparam int unsigned POS_W      = $clog2(CODE_DEPTH + 1);
	localparam int unsigned MAX_SIDE   = 1024;
	localparam int unsigned SIDE_W     = $clog2(MAX_SIDE + 1);
	localparam int unsigned SKIP_W     = $clog2(MAX_SIDE * MAX_SIDE) + 1;
	localparam int unsigned BIT_W      = $clog2(SIDE_W);
	localparam int unsigned PAL_DEPTH  = 256;
	localparam int unsigned PAL_AW     = $clog2(PAL_DEPTH);
	localparam int unsigned CFG_W      = 11;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [1:0] OP_LOAD_CODE = 2'd0;
	localparam logic [1:0] OP_LOAD_PAL  = 2'd1;
	localparam logic [1:0] OP_QUERY     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y     = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	typedef struct packed {
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
		logic [7:0]        key;
		logic              mirror_x;
		logic              mirror_y;
	} rsp_cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       overrun;
	} rsp_res_t;

endpackage

/* rtl/core/rle_sprite_pixel_fetch.sv */
// Top level: configuration registers, code and palette stores, query walker.
//
// Channel   Direction  Signals                               Handshake
// request   in         op addr code_byte rgb x y             start & !busy
// result    out        red green blue alpha overrun          done, one cycle
// config    in         cfg_index cfg_wdata                   cfg_we
//
// Loads give no result; an off-frame query answers in the next cycle. Other
// queries step through mirroring, the shift-add index, the walk over literal
// bytes and key and count pairs, and the target byte and palette read, and
// done shows when the walk ends. Reset clears control state only, not the
// stores. Results cannot be stalled; done rises in a cycle with busy low.
module rle_sprite_pixel_fetch (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  op,
	input  logic [15:0]                 addr,
	input  logic [7:0]                  code_byte,
	input  logic [23:0]                 rgb,
	input  logic signed [11:0]          x,
	input  logic signed [11:0]          y,
	input  logic                        cfg_we,
	input  logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsp_pkg::CFG_W-1:0]   cfg_wdata,
	output logic                        done,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic [7:0]                  alpha,
	output logic                        overrun
);

	logic [10:0]                   frame_width_q;
	logic [10:0]                   frame_height_q;
	logic [7:0]                    color_key_q;
	logic                          mirror_x_q;
	logic                          mirror_y_q;

	rsp_pkg::rsp_cfg_t             cfg;
	rsp_pkg::rsp_res_t             res;
	logic                          accept;
	logic                          code_we;
	logic                          pal_we;
	logic [rsp_pkg::CODE_AW-1:0]   code_raddr;
	logic [7:0]                    code_rdata;
	logic [rsp_pkg::PAL_AW-1:0]    pal_raddr;
	logic [23:0]                   pal_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd1;
			frame_height_q <= 11'd1;
			color_key_q    <= '0;
			mirror_x_q     <= 1'b0;
			mirror_y_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[10:0];
				rsp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[10:0];
				rsp_pkg::REG_COLOR_KEY:    color_key_q    <= cfg_wdata[7:0];
				rsp_pkg::REG_MIRROR_X:     mirror_x_q     <= cfg_wdata[0];
				rsp_pkg::REG_MIRROR_Y:     mirror_y_q     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// oversized sides clamp to the largest supported frame
	assign cfg.w = (32'(frame_width_q) > rsp_pkg::MAX_SIDE)
		? rsp_pkg::SIDE_W'(rsp_pkg::MAX_SIDE) : rsp_pkg::SIDE_W'(frame_width_q);
	assign cfg.h = (32'(frame_height_q) > rsp_pkg::MAX_SIDE)
		? rsp_pkg::SIDE_W'(rsp_pkg::MAX_SIDE) : rsp_pkg::SIDE_W'(frame_height_q);
	assign cfg.key      = color_key_q;
	assign cfg.mirror_x = mirror_x_q;
	assign cfg.mirror_y = mirror_y_q;

	assign accept  = start && !busy;
	assign code_we = accept && (op == rsp_pkg::OP_LOAD_CODE)
		&& (32'(addr) < rsp_pkg::CODE_DEPTH);
	assign pal_we  = accept && (op == rsp_pkg::OP_LOAD_PAL)
		&& (32'(addr) < rsp_pkg::PAL_DEPTH);

	rsp_ram #(
		.DEPTH (rsp_pkg::CODE_DEPTH),
		.WIDTH (8)
	) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.waddr (rsp_pkg::CODE_AW'(addr)),
		.wdata (code_byte),
		.raddr (code_raddr),
		.rdata (code_rdata)
	);

	rsp_ram #(
		.DEPTH (rsp_pkg::PAL_DEPTH),
		.WIDTH (24)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (rsp_pkg::PAL_AW'(addr)),
		.wdata (rgb),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	rsp_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (accept && (op == rsp_pkg::OP_QUERY)),
		.x          (x),
		.y          (y),
		.cfg        (cfg),
		.code_rdata (code_rdata),
		.pal_rdata  (pal_rdata),
		.code_raddr (code_raddr),
		.pal_raddr  (pal_raddr),
		.busy       (busy),
		.res        (res)
	);

	assign done    = res.valid;
	assign red     = res.red;
	assign green   = res.green;
	assign blue    = res.blue;
	assign alpha   = res.alpha;
	assign overrun = res.overrun;

endmodule

/* rtl/core/rsp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rsp_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/rsp_alu.sv */
// Shared adder of the walker: a + b, or a - b - 1 when b is inverted.
module rsp_alu (
	input  logic                      inv_b,
	input  logic [rsp_pkg::SKIP_W-1:0] a,
	input  logic [rsp_pkg::SKIP_W-1:0] b,
	output logic [rsp_pkg::SKIP_W-1:0] sum
);

	assign sum = a + (inv_b ? ~b : b);

endmodule

/* rtl/core/rsp_walk.sv */
// Query sequencer: bounds check, mirroring, shift-add index and code walk.
module rsp_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [11:0]                   x,
	input  logic [11:0]                   y,
	input  rsp_pkg::rsp_cfg_t             cfg,
	input  logic [7:0]                    code_rdata,
	input  logic [23:0]                   pal_rdata,
	output logic [rsp_pkg::CODE_AW-1:0]   code_raddr,
	output logic [rsp_pkg::PAL_AW-1:0]    pal_raddr,
	output logic                          busy,
	output rsp_pkg::rsp_res_t             res
);

	typedef enum logic [3:0] {
		S_IDLE, S_MIRY, S_MIRX, S_MUL, S_ADDX, S_LOOP, S_BYTE, S_CNT, S_LAST, S_PAL
	} state_t;

	state_t                      state_q;
	logic [rsp_pkg::SIDE_W-1:0]  px_q;
	logic [rsp_pkg::SIDE_W-1:0]  py_q;
	logic [rsp_pkg::SKIP_W-1:0]  acc_q;
	logic [rsp_pkg::BIT_W-1:0]   bit_q;
	logic [rsp_pkg::POS_W-1:0]   pos_q;
	rsp_pkg::rsp_res_t           res_q;

	logic                        inv_b;
	logic [rsp_pkg::SKIP_W-1:0]  op_a;
	logic [rsp_pkg::SKIP_W-1:0]  op_b;
	logic [rsp_pkg::SKIP_W-1:0]  sum;
	logic                        in_frame;
	logic                        acc_pos;
	logic                        acc_zero;
	logic                        past_end;

	rsp_alu u_alu (
		.inv_b (inv_b),
		.a     (op_a),
		.b     (op_b),
		.sum   (sum)
	);

	assign in_frame = !x[11] && !y[11]
		&& (32'(x[10:0]) < 32'(cfg.w)) && (32'(y[10:0]) < 32'(cfg.h));
	assign acc_zero = (acc_q == '0);
	assign acc_pos  = !acc_q[rsp_pkg::SKIP_W-1] && !acc_zero;
	assign past_end = (32'(pos_q) >= rsp_pkg::CODE_DEPTH);

	assign code_raddr = pos_q[rsp_pkg::CODE_AW-1:0];
	assign pal_raddr  = code_rdata;
	assign busy       = (state_q != S_IDLE);
	assign res        = res_q;

	always_comb begin
		inv_b = 1'b0;
		op_a  = acc_q;
		op_b  = '0;
		unique case (state_q)
			S_MIRY: begin
				inv_b = 1'b1;
				op_a  = rsp_pkg::SKIP_W'(cfg.h);
				op_b  = rsp_pkg::SKIP_W'(py_q);
			end
			S_MIRX: begin
				inv_b = 1'b1;
				op_a  = rsp_pkg::SKIP_W'(cfg.w);
				op_b  = rsp_pkg::SKIP_W'(px_q);
			end
			S_MUL: begin
				op_a = {acc_q[rsp_pkg::SKIP_W-2:0], 1'b0};
				op_b = cfg.w[bit_q] ? rsp_pkg::SKIP_W'(py_q) : '0;
			end
			S_ADDX: begin
				op_b = rsp_pkg::SKIP_W'(px_q);
			end
			S_BYTE: begin
				// acc + ~0 = acc - 1
				inv_b = 1'b1;
			end
			S_CNT: begin
				inv_b = 1'b1;
				op_b  = rsp_pkg::SKIP_W'(code_rdata);
			end
			default: begin
				inv_b = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			px_q    <= '0;
			py_q    <= '0;
			acc_q   <= '0;
			bit_q   <= '0;
			pos_q   <= '0;
			res_q   <= '0;
		end else begin
			res_q.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						res_q <= '0;
						if (in_frame) begin
							px_q    <= rsp_pkg::SIDE_W'(x[10:0]);
							py_q    <= rsp_pkg::SIDE_W'(y[10:0]);
							acc_q   <= '0;
							bit_q   <= rsp_pkg::BIT_W'(rsp_pkg::SIDE_W - 1);
							pos_q   <= '0;
							state_q <= S_MIRY;
						end else begin
							res_q.valid <= 1'b1;
						end
					end
				end
				S_MIRY: begin
					if (cfg.mirror_y) begin
						py_q <= sum[rsp_pkg::SIDE_W-1:0];
					end
					state_q <= S_MIRX;
				end
				S_MIRX: begin
					if (cfg.mirror_x) begin
						px_q <= sum[rsp_pkg::SIDE_W-1:0];
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					// MSB-first shift-add of py * width
					acc_q <= sum;
					if (bit_q == '0) begin
						state_q <= S_ADDX;
					end else begin
						bit_q <= bit_q - rsp_pkg::BIT_W'(1);
					end
				end
				S_ADDX: begin
					acc_q   <= sum;
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (acc_pos || acc_zero) begin
						if (past_end) begin
							res_q.valid   <= 1'b1;
							res_q.overrun <= 1'b1;
							state_q       <= S_IDLE;
						end else if (acc_pos) begin
							pos_q   <= pos_q + rsp_pkg::POS_W'(1);
							state_q <= S_BYTE;
						end else begin
							state_q <= S_LAST;
						end
					end else begin
						// target fell inside a skipped run
						res_q.valid <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_BYTE: begin
					if (code_rdata == cfg.key) begin
						if (past_end) begin
							res_q.valid   <= 1'b1;
							res_q.overrun <= 1'b1;
							state_q       <= S_IDLE;
						end else begin
							pos_q   <= pos_q + rsp_pkg::POS_W'(1);
							state_q <= S_CNT;
						end
					end else begin
						acc_q   <= sum;
						state_q <= S_LOOP;
					end
				end
				S_CNT: begin
					acc_q   <= sum;
					state_q <= S_LOOP;
				end
				S_LAST: begin
					if (code_rdata == cfg.key) begin
						res_q.valid <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_PAL;
					end
				end
				S_PAL: begin
					res_q.valid <= 1'b1;
					res_q.red   <= pal_rdata[23:16];
					res_q.green <= pal_rdata[15:8];
					res_q.blue  <= pal_rdata[7:0];
					res_q.alpha <= rsp_pkg::ALPHA_OPAQUE;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/rsp_checker.sv */
// Port-level checks on the pixel fetch, bound to the top level.
module rsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] op,
	input logic       done,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha,
	input logic       overrun
);

	// a walk only begins on a taken query request
	a_busy_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(op) == rsp_pkg::OP_QUERY)
		else $error("busy rose without a query request");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still walking");

	a_alpha_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> alpha == 8'h00 || alpha == rsp_pkg::ALPHA_OPAQUE)
		else $error("alpha neither clear nor opaque");

	a_clear_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && alpha == 8'h00 |-> red == 8'h00 && green == 8'h00 && blue == 8'h00)
		else $error("transparent pixel not black");

	a_overrun_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && overrun |-> alpha == 8'h00)
		else $error("overrun with an opaque pixel");

endmodule

bind rle_sprite_pixel_fetch rsp_checker u_rsp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.op      (op),
	.done    (done),
	.red     (red),
	.green   (green),
	.blue    (blue),
	.alpha   (alpha),
	.overrun (overrun)
);

/* dv/tb_rle_sprite_pixel_fetch.sv */
// Self-checking testbench for the run-length sprite pixel fetch block.
module tb_rle_sprite_pixel_fetch;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int RANDOM_ITEMS         = 450;
	localparam int QUIET_CYCLES         = 8;
	localparam int WATCHDOG_LIMIT       = 600000;

	typedef struct {
		logic [1:0]         op;
		logic [15:0]        addr;
		logic [7:0]         code_byte;
		logic [23:0]        rgb;
		logic signed [11:0] x;
		logic signed [11:0] y;
	} request_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       overrun;
	} pixel_t;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          start     = 1'b0;
	logic                          busy;
	logic [1:0]                    op        = '0;
	logic [15:0]                   addr      = '0;
	logic [7:0]                    code_byte = '0;
	logic [23:0]                   rgb       = '0;
	logic signed [11:0]            x         = '0;
	logic signed [11:0]            y         = '0;
	logic                          cfg_we    = 1'b0;
	logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rsp_pkg::CFG_W-1:0]     cfg_wdata = '0;
	logic                          done;
	logic [7:0]                    red;
	logic [7:0]                    green;
	logic [7:0]                    blue;
	logic [7:0]                    alpha;
	logic                          overrun;

	// Mirror of the block's registers and stores
	logic [10:0] cfg_width    = 11'd1;
	logic [10:0] cfg_height   = 11'd1;
	logic [7:0]  cfg_key      = 8'd0;
	logic        cfg_mirror_x = 1'b0;
	logic        cfg_mirror_y = 1'b0;
	logic [7:0]  code_mem [rsp_pkg::CODE_DEPTH];
	bit          code_written [rsp_pkg::CODE_DEPTH];
	logic [23:0] pal_mem [rsp_pkg::PAL_DEPTH];
	bit          pal_written [rsp_pkg::PAL_DEPTH];

	pixel_t expected_pixels [$];
	int     error_count    = 0;
	int     accepted_items = 0;
	int     sprite_pixels  = 0;
	int     stall_cycles   = 0;

	rle_sprite_pixel_fetch DUT (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int side_limit(input logic [10:0] v);
		return (32'(v) > rsp_pkg::MAX_SIDE) ? int'(rsp_pkg::MAX_SIDE) : int'(v);
	endfunction

	// Returns 0 if the walk would touch a store entry never written.
	function automatic bit predict_pixel(input logic signed [11:0] qx,
			input logic signed [11:0] qy, output pixel_t pix);
		int w, h, px, py, pos;
		longint remaining;
		logic [7:0] b;
		pix = '0;
		w = side_limit(cfg_width);
		h = side_limit(cfg_height);
		px = int'(qx);
		py = int'(qy);
		if (px < 0 || px >= w || py < 0 || py >= h)
			return 1'b1;
		if (cfg_mirror_y)
			py = h - py - 1;
		if (cfg_mirror_x)
			px = w - px - 1;
		remaining = longint'(py) * w + px;
		pos = 0;
		while (remaining > 0) begin
			if (pos >= rsp_pkg::CODE_DEPTH) begin
				pix.overrun = 1'b1;
				return 1'b1;
			end
			if (!code_written[pos])
				return 1'b0;
			b = code_mem[pos];
			pos++;
			if (b == cfg_key) begin
				if (pos >= rsp_pkg::CODE_DEPTH) begin
					pix.overrun = 1'b1;
					return 1'b1;
				end
				if (!code_written[pos])
					return 1'b0;
				remaining -= longint'(code_mem[pos]) + 1;
				pos++;
			end else begin
				remaining--;
			end
		end
		if (remaining < 0)
			return 1'b1;
		if (pos >= rsp_pkg::CODE_DEPTH) begin
			pix.overrun = 1'b1;
			return 1'b1;
		end
		if (!code_written[pos])
			return 1'b0;
		b = code_mem[pos];
		if (b == cfg_key)
			return 1'b1;
		if (!pal_written[b])
			return 1'b0;
		{pix.red, pix.green, pix.blue} = pal_mem[b];
		pix.alpha = rsp_pkg::ALPHA_OPAQUE;
		return 1'b1;
	endfunction

	function automatic request_t random_request();
		request_t req;
		req.op = 2'($urandom);
		req.addr = 16'($urandom);
		req.code_byte = 8'($urandom);
		req.rgb = 24'($urandom);
		req.x = 12'($urandom);
		req.y = 12'($urandom);
		return req;
	endfunction

	task automatic accept_request(input request_t req);
		pixel_t pix;
		case (req.op)
			rsp_pkg::OP_LOAD_CODE: begin
				if (32'(req.addr) < rsp_pkg::CODE_DEPTH) begin
					code_mem[req.addr] = req.code_byte;
					code_written[req.addr] = 1'b1;
				end
			end
			rsp_pkg::OP_LOAD_PAL: begin
				if (32'(req.addr) < rsp_pkg::PAL_DEPTH) begin
					pal_mem[req.addr] = req.rgb;
					pal_written[req.addr] = 1'b1;
				end
			end
			rsp_pkg::OP_QUERY: begin
				void'(predict_pixel(req.x, req.y, pix));
				expected_pixels.push_back(pix);
			end
			default: ;
		endcase
		accepted_items++;
	endtask

	// Leaves start high; the next request or a gap decides what follows.
	task automatic send_request(input request_t req);
		@(negedge clk);
		start     <= 1'b1;
		op        <= req.op;
		addr      <= req.addr;
		code_byte <= req.code_byte;
		rgb       <= req.rgb;
		x         <= req.x;
		y         <= req.y;
		do @(posedge clk); while (busy);
		accept_request(req);
	endtask

	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic load_code(input int a, input int b);
		request_t req;
		req = random_request();
		req.op = rsp_pkg::OP_LOAD_CODE;
		req.addr = 16'(a);
		req.code_byte = 8'(b);
		send_request(req);
	endtask

	task automatic load_palette(input int a, input int colour);
		request_t req;
		req = random_request();
		req.op = rsp_pkg::OP_LOAD_PAL;
		req.addr = 16'(a);
		req.rgb = 24'(colour);
		send_request(req);
	endtask

	task automatic send_unused_op();
		request_t req;
		req = random_request();
		req.op = OP_UNUSED;
		send_request(req);
	endtask

	task automatic query_pixel(input int qx, input int qy);
		request_t req;
		pixel_t pix;
		req = random_request();
		req.op = rsp_pkg::OP_QUERY;
		req.x = 12'(qx);
		req.y = 12'(qy);
		// walking into an unwritten store entry is off limits: fall back to an off-frame query
		if (!predict_pixel(req.x, req.y, pix))
			req.x = -12'sd1;
		send_request(req);
	endtask

	task automatic safe_query();
		int w, h, idx, qx, qy, t;
		bit found;
		pixel_t pix;
		w = side_limit(cfg_width);
		h = side_limit(cfg_height);
		found = 1'b0;
		qx = -1;
		qy = 0;
		if (w * h > 0) begin
			for (t = 0; t < 8 && !found; t++) begin
				if (sprite_pixels == 0 || $urandom_range(0, 3) == 0) begin
					qx = $urandom_range(0, w - 1);
					qy = $urandom_range(0, h - 1);
				end else begin
					idx = $urandom_range(0, ((sprite_pixels < w * h) ? sprite_pixels : w * h) - 1);
					qx = idx % w;
					qy = idx / w;
					if (cfg_mirror_x)
						qx = w - 1 - qx;
					if (cfg_mirror_y)
						qy = h - 1 - qy;
				end
				found = predict_pixel(12'(qx), 12'(qy), pix);
			end
		end
		query_pixel(found ? qx : -1, qy);
	endtask

	// Writes a sprite from code address 0 covering at least npix pixels
	task automatic encode_sprite(input int npix, input int run_pct, input int max_run,
			input int idle_pct);
		int covered, a, cnt;
		logic [7:0] b;
		covered = 0;
		a = 0;
		while (covered < npix) begin
			if ($urandom_range(0, 99) < run_pct) begin
				cnt = $urandom_range(0, max_run);
				load_code(a, int'(cfg_key));
				sender_gap(idle_pct);
				load_code(a + 1, cnt);
				a += 2;
				covered += cnt + 1;
			end else begin
				do b = 8'($urandom); while (b == cfg_key);
				load_code(a, int'(b));
				a++;
				covered++;
			end
			sender_gap(idle_pct);
		end
		sprite_pixels = covered;
	endtask

	task automatic drain_requests();
		@(negedge clk);
		start <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rsp_pkg::CFG_IDX_W-1:0] idx,
			input logic [rsp_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
	endtask

	task automatic write_frame(input int w, input int h, input int key, input int mx,
			input int my);
		drain_requests();
		write_reg(rsp_pkg::REG_FRAME_WIDTH, rsp_pkg::CFG_W'(w));
		write_reg(rsp_pkg::REG_FRAME_HEIGHT, rsp_pkg::CFG_W'(h));
		write_reg(rsp_pkg::REG_COLOR_KEY, rsp_pkg::CFG_W'(key & 'hff));
		write_reg(rsp_pkg::REG_MIRROR_X, rsp_pkg::CFG_W'(mx & 1));
		write_reg(rsp_pkg::REG_MIRROR_Y, rsp_pkg::CFG_W'(my & 1));
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_width    = 11'(w);
		cfg_height   = 11'(h);
		cfg_key      = 8'(key);
		cfg_mirror_x = 1'(mx);
		cfg_mirror_y = 1'(my);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : result_check
		pixel_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unrequested result", {red, green, blue, alpha}, '0);
			end else begin
				want = expected_pixels.pop_front();
				if (red !== want.red)
					report_mismatch("red", 32'(red), 32'(want.red));
				if (green !== want.green)
					report_mismatch("green", 32'(green), 32'(want.green));
				if (blue !== want.blue)
					report_mismatch("blue", 32'(blue), 32'(want.blue));
				if (alpha !== want.alpha)
					report_mismatch("alpha", 32'(alpha), 32'(want.alpha));
				if (overrun !== want.overrun)
					report_mismatch("overrun", 32'(overrun), 32'(want.overrun));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic test_palette_load();
		int i;
		for (i = 0; i < rsp_pkg::PAL_DEPTH; i++)
			load_palette(i, (i == 1) ? 'hffffff : (i == 2) ? 'h000000 : int'($urandom));
	endtask

	task automatic test_directed_cases();
		int i;
		// reset frame is a single pixel with key 0
		load_code(0, 'h5a);
		query_pixel(0, 0);
		query_pixel(1, 0);
		query_pixel(0, -1);
		query_pixel(-2048, 2047);
		query_pixel(2047, -2048);
		send_unused_op();
		// palette indexes above 255 must not land anywhere
		load_palette('h0100, 'h123456);
		load_palette('hffff, 'hffffff);
		load_palette('h005a, 'hffffff);
		query_pixel(0, 0);
		load_palette('h0011, 'h000000);
		load_code(0, 'h00);
		query_pixel(0, 0);
		write_frame(4, 1, 'hff, 0, 0);
		load_code(0, 'h11);
		load_code(1, 'hff);
		load_code(2, 'h01);
		load_code(3, 'h22);
		for (i = 0; i <= 4; i++)
			query_pixel(i, 0);
	endtask

	task automatic test_frame_extremes();
		write_frame(0, 5, 'hff, 0, 0);
		query_pixel(0, 0);
		query_pixel(2, 1);
		write_frame(5, 0, 'hff, 0, 0);
		query_pixel(0, 0);
		// oversized width clamps to the largest side
		write_frame(2047, 2, 'hff, 0, 0);
		encode_sprite(2048, 90, 255, 0);
		query_pixel(0, 0);
		query_pixel(1023, 0);
		query_pixel(1024, 0);
		query_pixel(0, 1);
		query_pixel(1023, 1);
		query_pixel(-1, 1);
		write_frame(1024, 2, 'hff, 1, 1);
		query_pixel(0, 0);
		query_pixel(1023, 1);
		query_pixel(512, 0);
		repeat (6) safe_query();
	endtask

	task automatic test_mirroring();
		int m, i, j, key;
		key = $urandom_range(0, 255);
		write_frame(3, 2, key, 0, 0);
		encode_sprite(6, 30, 2, 0);
		for (m = 0; m < 4; m++) begin
			write_frame(3, 2, key, m & 1, m >> 1);
			for (j = 0; j < 2; j++)
				for (i = 0; i < 3; i++)
					query_pixel(i, j);
		end
	endtask

	task automatic test_random_scenes();
		int first_count, scene, idle_pct, kind, w, h, pick;
		first_count = accepted_items;
		scene = 0;
		while (accepted_items - first_count < RANDOM_ITEMS) begin
			case ((scene / 3) % 3)
				0: idle_pct = 0;
				1: idle_pct = 50;
				default: idle_pct = 29;
			endcase
			kind = $urandom_range(0, 15);
			if (kind == 0) begin
				// full-width frame, only its first rows coded
				write_frame($urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047),
					$urandom_range(2, 2047), $urandom, $urandom, $urandom);
				encode_sprite(2048, 90, 255, idle_pct);
			end else if (kind == 1) begin
				write_frame($urandom_range(0, 3), $urandom_range(0, 3), $urandom, $urandom,
					$urandom);
				encode_sprite(4, 30, 3, idle_pct);
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 12);
				write_frame(w, h, $urandom, $urandom, $urandom);
				// now and then the sprite is cut short
				encode_sprite((kind == 2) ? (w * h) / 2 : w * h, 30, 6, idle_pct);
			end
			repeat ($urandom_range(8, 20)) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					safe_query();
				else if (pick < 80)
					query_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
				else if (pick < 86)
					load_palette($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom,
						$urandom);
				else if (pick < 94)
					load_code($urandom_range(0, 65535), $urandom_range(0, 255));
				else
					send_unused_op();
				sender_gap(idle_pct);
			end
			scene++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_palette_load();
		test_directed_cases();
		test_frame_extremes();
		test_mirroring();
		test_random_scenes();
		drain_requests();
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
